### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every check is sampled on the rising edge of clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CHECK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

### hw/rtl/rlps_pkg.sv
package rlps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int WORD_BITS   = 24;
    localparam int BITS_LEFT_W = 5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_GAP = 3'd4;

    localparam logic [7:0]  ONE_HIGH_RST  = 8'd17;
    localparam logic [7:0]  ONE_LOW_RST   = 8'd8;
    localparam logic [7:0]  ZERO_HIGH_RST = 8'd4;
    localparam logic [7:0]  ZERO_LOW_RST  = 8'd14;
    localparam logic [15:0] RESET_GAP_RST = 16'd85;

    typedef struct packed {
        logic       command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic load_refused;
        logic frame_done;
    } out_item_t;

    // Classified command handed from the front end to the waveform engine.
    typedef struct packed {
        logic                 is_tick;
        logic [WORD_BITS-1:0] word;
    } cmd_t;

endpackage

### hw/rtl/rlps_fifo.sv
module rlps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/rlps_front.sv
module rlps_front (
    input  logic               push,
    input  rlps_pkg::in_item_t item,
    output logic               full,
    output logic               cmd_push,
    output rlps_pkg::cmd_t     cmd,
    input  logic               cmd_full
);

    // Classify the item and reorder the color into the wire order green, red, blue.
    assign cmd_push     = push & ~cmd_full;
    assign full         = cmd_full;
    assign cmd.is_tick  = (item.command == rlps_pkg::CMD_TICK);
    assign cmd.word     = {item.green, item.red, item.blue};

endmodule

### hw/rtl/rlps_back.sv
`include "assert_macros.svh"

module rlps_back #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [rlps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rlps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 cmd_valid,
    input  rlps_pkg::cmd_t                       cmd,
    output logic                                 cmd_pop,
    input  logic                                 res_full,
    output logic                                 res_push,
    output rlps_pkg::out_item_t                  res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_GAP  = 2'd3;

    localparam int TW = TICK_COUNT_WIDTH;
    localparam int WB = rlps_pkg::WORD_BITS;
    localparam int BW = rlps_pkg::BITS_LEFT_W;

    logic [7:0]  one_high_reg;
    logic [7:0]  one_low_reg;
    logic [7:0]  zero_high_reg;
    logic [7:0]  zero_low_reg;
    logic [15:0] gap_reg;

    logic [WB-1:0] shift_reg, shift_next;
    logic [BW-1:0] bits_reg, bits_next;
    logic [1:0]    phase_reg, phase_next;
    logic [TW-1:0] ticks_reg, ticks_next;
    logic [TW-1:0] ticks_dec;
    logic [WB-1:0] shifted;
    logic          refused;
    logic          done;

    // A zero duration counts as one tick; a duration beyond the counter saturates.
    function automatic logic [TW-1:0] dur(input logic [15:0] v);
        logic [32:0] wide;
        logic [32:0] lim;
        wide = {17'd0, v};
        lim  = (33'd1 << TW) - 33'd1;
        if (v == 16'd0)
        begin
            wide = 33'd1;
        end
        if (wide > lim)
        begin
            wide = lim;
        end
        return wide[TW-1:0];
    endfunction

    assign cmd_pop  = cmd_valid & ~res_full;
    assign res_push = cmd_pop;
    assign ticks_dec = (ticks_reg != '0) ? ticks_reg - TW'(1) : '0;
    assign shifted   = {shift_reg[WB-2:0], 1'b0};

    always_comb
    begin
        shift_next = shift_reg;
        bits_next  = bits_reg;
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        refused    = 1'b0;
        done       = 1'b0;
        if (!cmd.is_tick)
        begin
            if (phase_reg != PH_IDLE)
            begin
                refused = 1'b1;
            end
            else
            begin
                shift_next = cmd.word;
                bits_next  = BW'(WB);
                phase_next = PH_HIGH;
                ticks_next = dur(cmd.word[WB-1] ? {8'd0, one_high_reg} : {8'd0, zero_high_reg});
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            ticks_next = ticks_dec;
            if (ticks_dec == '0)
            begin
                case (phase_reg)
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        ticks_next = dur(shift_reg[WB-1] ? {8'd0, one_low_reg}
                                                         : {8'd0, zero_low_reg});
                    end
                    PH_LOW:
                    begin
                        shift_next = shifted;
                        bits_next  = bits_reg - 1'b1;
                        if (bits_reg != BW'(1))
                        begin
                            phase_next = PH_HIGH;
                            ticks_next = dur(shifted[WB-1] ? {8'd0, one_high_reg}
                                                           : {8'd0, zero_high_reg});
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                            ticks_next = dur(gap_reg);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        ticks_next = '0;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    assign res.line_level   = (phase_next == PH_HIGH);
    assign res.busy_res     = (phase_next != PH_IDLE);
    assign res.load_refused = refused;
    assign res.frame_done   = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= rlps_pkg::ONE_HIGH_RST;
            one_low_reg   <= rlps_pkg::ONE_LOW_RST;
            zero_high_reg <= rlps_pkg::ZERO_HIGH_RST;
            zero_low_reg  <= rlps_pkg::ZERO_LOW_RST;
            gap_reg       <= rlps_pkg::RESET_GAP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rlps_pkg::REG_ONE_HIGH:  one_high_reg  <= cfg_data[7:0];
                rlps_pkg::REG_ONE_LOW:   one_low_reg   <= cfg_data[7:0];
                rlps_pkg::REG_ZERO_HIGH: zero_high_reg <= cfg_data[7:0];
                rlps_pkg::REG_ZERO_LOW:  zero_low_reg  <= cfg_data[7:0];
                rlps_pkg::REG_RESET_GAP: gap_reg       <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            bits_reg  <= '0;
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
        end
        else if (cmd_pop)
        begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
        end
    end

    // The tick counter is empty exactly when the line is idle.
    `ASSERT_CHECK(a_ticks_idle, (phase_reg == PH_IDLE) == (ticks_reg == '0))
    // A bit phase always has bits still to send, never more than one word.
    `ASSERT_NEVER(a_bits_range, bits_reg > BW'(WB))
    `ASSERT_NEVER(a_bits_phase, (phase_reg == PH_HIGH || phase_reg == PH_LOW) && bits_reg == '0)
    // A refused load leaves the waveform state untouched.
    `ASSERT_CHECK(a_refuse_hold, cmd_pop && refused |=> $stable(phase_reg) && $stable(ticks_reg))

endmodule

### hw/rtl/rgb_led_pulse_width_serializer.sv
// Channel   Direction  Handshake              Payload
// item      in         push / full            rlps_pkg::in_item_t (command, red, green, blue)
// result    out        empty / pop            rlps_pkg::out_item_t (line, busy, refused, done)
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while full is low, and one result per item is produced per
// cycle while the result queue has room. A result reaches the result port by way of the
// command queue and the result queue: the waveform engine writes its result straight
// into the result queue in the cycle it takes the command.
// Both queues hold two entries; a stalled result side fills them and then raises full.
// Reset is asynchronous: the line goes idle and the timing registers take their defaults.
// cfg_ready is always high; a configuration write lands in the timing registers at once.
module rgb_led_pulse_width_serializer #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  rlps_pkg::in_item_t               item,
    output logic                             empty,
    input  logic                             pop,
    output rlps_pkg::out_item_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rlps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rlps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CMD_W = $bits(rlps_pkg::cmd_t);
    localparam int RES_W = $bits(rlps_pkg::out_item_t);

    rlps_pkg::cmd_t      front_cmd;
    rlps_pkg::cmd_t      back_cmd;
    rlps_pkg::out_item_t back_res;
    logic                cmd_push;
    logic                cmd_full;
    logic                cmd_empty;
    logic                cmd_pop;
    logic                res_push;
    logic                res_full;

    assign cfg_ready = 1'b1;

    // The front end classifies each transfer as a load or a tick and builds the wire word.
    rlps_front u_front (
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (front_cmd),
        .cmd_full (cmd_full)
    );

    // Short queue that decouples the front end from the waveform engine.
    rlps_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    // The waveform engine walks the bit, low and gap phases with one tick counter.
    rlps_back #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (~cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    // Result queue, so the engine keeps going while the consumer holds off pop.
    rlps_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

### verif/led_line_checker.sv
`timescale 1ns / 100ps

module led_line_checker
    import rlps_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  in_item_t               item,
    input  logic                   empty,
    input  logic                   pop,
    input  out_item_t              result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   finishing,
    output int                     fail_count
);

    typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_GAP} line_phase_e;

    localparam int MAX_REPORTS = 10;

    // Timing registers as the block should hold them.
    logic [7:0]  one_high = ONE_HIGH_RST;
    logic [7:0]  one_low = ONE_LOW_RST;
    logic [7:0]  zero_high = ZERO_HIGH_RST;
    logic [7:0]  zero_low = ZERO_LOW_RST;
    logic [15:0] gap_len = RESET_GAP_RST;

    // Waveform state.
    logic [WORD_BITS-1:0]   grb_word = '0;
    logic [BITS_LEFT_W-1:0] bits_left = '0;
    line_phase_e            phase = LINE_IDLE;
    logic [31:0]            ticks_left = '0;

    out_item_t   expected_line_q[$];
    int          errors = 0;
    int unsigned results_seen = 0;
    bit          leftover_done = 1'b0;

    assign fail_count = errors;

    // A zero setting lasts one tick; a setting beyond the counter saturates.
    function automatic logic [31:0] phase_length(input logic [15:0] setting);
        logic [63:0] limit;
        limit = (64'd1 << TICK_COUNT_WIDTH) - 64'd1;
        if (setting == 16'd0)
        begin
            return 32'd1;
        end
        if ({48'd0, setting} > limit)
        begin
            return limit[31:0];
        end
        return {16'd0, setting};
    endfunction

    function automatic void begin_bit();
        phase = LINE_HIGH;
        ticks_left = grb_word[WORD_BITS-1] ? phase_length({8'd0, one_high})
                                           : phase_length({8'd0, zero_high});
    endfunction

    function automatic out_item_t advance_line(input in_item_t it);
        out_item_t r;
        r = '0;
        if (it.command == CMD_LOAD)
        begin
            if (phase != LINE_IDLE)
            begin
                r.load_refused = 1'b1;
            end
            else
            begin
                grb_word = {it.green, it.red, it.blue};
                bits_left = BITS_LEFT_W'(WORD_BITS);
                begin_bit();
            end
        end
        else if (phase != LINE_IDLE)
        begin
            if (ticks_left != 0)
            begin
                ticks_left = ticks_left - 1;
            end
            if (ticks_left == 0)
            begin
                case (phase)
                    LINE_HIGH:
                    begin
                        phase = LINE_LOW;
                        ticks_left = grb_word[WORD_BITS-1] ? phase_length({8'd0, one_low})
                                                           : phase_length({8'd0, zero_low});
                    end
                    LINE_LOW:
                    begin
                        grb_word = grb_word << 1;
                        bits_left = bits_left - 1'b1;
                        if (bits_left != 0)
                        begin
                            begin_bit();
                        end
                        else
                        begin
                            phase = LINE_GAP;
                            ticks_left = phase_length(gap_len);
                        end
                    end
                    default:
                    begin
                        phase = LINE_IDLE;
                        ticks_left = '0;
                        r.frame_done = 1'b1;
                    end
                endcase
            end
        end
        r.line_level = (phase == LINE_HIGH);
        r.busy_res = (phase != LINE_IDLE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            one_high = ONE_HIGH_RST;
            one_low = ONE_LOW_RST;
            zero_high = ZERO_HIGH_RST;
            zero_low = ZERO_LOW_RST;
            gap_len = RESET_GAP_RST;
            grb_word = '0;
            bits_left = '0;
            phase = LINE_IDLE;
            ticks_left = '0;
            expected_line_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ONE_HIGH:  one_high = cfg_data[7:0];
                    REG_ONE_LOW:   one_low = cfg_data[7:0];
                    REG_ZERO_HIGH: zero_high = cfg_data[7:0];
                    REG_ZERO_LOW:  zero_low = cfg_data[7:0];
                    REG_RESET_GAP: gap_len = cfg_data[15:0];
                    default: ;
                endcase
            end

            if (push && !full)
            begin
                expected_line_q.push_back(advance_line(item));
            end

            if (pop && !empty)
            begin
                results_seen++;
                if (expected_line_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("result %0d arrived with nothing expected", results_seen);
                    end
                end
                else
                begin
                    want = expected_line_q.pop_front();
                    if (result.line_level !== want.line_level ||
                        result.busy_res !== want.busy_res ||
                        result.load_refused !== want.load_refused ||
                        result.frame_done !== want.frame_done)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("result %0d: expected line %b busy %b refused %b done %b,",
                                     results_seen, want.line_level, want.busy_res,
                                     want.load_refused, want.frame_done,
                                     " got line %b busy %b refused %b done %b",
                                     result.line_level, result.busy_res,
                                     result.load_refused, result.frame_done);
                        end
                    end
                end
            end

            if (finishing && !leftover_done)
            begin
                leftover_done = 1'b1;
                if (expected_line_q.size() != 0)
                begin
                    errors += expected_line_q.size();
                    $display("%0d expected results never arrived", expected_line_q.size());
                end
            end
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the RGB LED line serializer. The block is driven
// through its item queue, its result queue and its configuration channel; the
// checker instance beside it predicts every result and counts failures.
module testbench;
    import rlps_pkg::*;

    localparam int TICK_W = 16;
    localparam int IDLE_MAX = 13;
    localparam int OPENING_TICKS = 36;
    localparam int RANDOM_PHASES = 3;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int LOAD_ODDS = 12;
    localparam int PRESSURE_AT = 60;
    localparam int PRESSURE_HOLD = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_RESET_GAP + 1'b1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    in_item_t               item = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    out_item_t              result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   finishing = 1'b0;
    int                     fail_count;

    // When set, neither side inserts random idle cycles; the receiver's long holds still occur.
    bit          no_idle = 1'b0;
    int unsigned items_sent = 0;
    int unsigned results_taken = 0;
    // Busy flag of the most recent result taken; tells the sender when a frame is over.
    logic        last_busy = 1'b0;
    int unsigned cycles = 0;

    rgb_led_pulse_width_serializer #(
        .TICK_COUNT_WIDTH(TICK_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    led_line_checker #(
        .TICK_COUNT_WIDTH(TICK_W)
    ) line_check (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .finishing(finishing),
        .fail_count(fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned idle_draw();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic in_item_t colour_item(input logic cmd, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
        in_item_t it;
        it.command = cmd;
        it.red = r;
        it.green = g;
        it.blue = b;
        return it;
    endfunction

    // Random color fields; the command is a load once in load_odds on average.
    // Ticks carry random colors too, since the block must ignore them.
    function automatic in_item_t random_item(input int unsigned load_odds);
        logic cmd;
        cmd = ($urandom_range(1, load_odds) == 1) ? CMD_LOAD : CMD_TICK;
        return colour_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Offers one item after a random pause and returns at the edge of its transfer.
    // Push stays high on return so back-to-back items need no extra cycle.
    task automatic send_item(input in_item_t it);
        int unsigned pause;
        pause = idle_draw();
        if (pause != 0)
        begin
            push <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        item <= it;
        push <= 1'b1;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_timing(input logic [15:0] one_hi, input logic [15:0] one_lo,
                              input logic [15:0] zero_hi, input logic [15:0] zero_lo,
                              input logic [15:0] gap);
        write_reg(REG_ONE_HIGH, one_hi);
        write_reg(REG_ONE_LOW, one_lo);
        write_reg(REG_ZERO_HIGH, zero_hi);
        write_reg(REG_ZERO_LOW, zero_lo);
        write_reg(REG_RESET_GAP, gap);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits until every item has come back as a result, so
    // nothing is in flight and the timing registers may be rewritten.
    task automatic drain_queues();
        push <= 1'b0;
        while (results_taken != items_sent) @(posedge clk);
    endtask

    // Keeps ticking until the line has gone idle and every result is back. A result
    // with busy low only counts once the queues have drained, since a load may still
    // be in flight.
    task automatic finish_frame();
        bit settled;
        settled = 1'b0;
        while (!settled)
        begin
            send_item(random_item(0 + 1'b0 + 32'hFFFF_FFFF));
            if (!last_busy)
            begin
                drain_queues();
                settled = !last_busy;
            end
        end
    endtask

    // Result side: a random pause before each transfer, occasional long holds, and
    // one long hold early on while the sender keeps offering, so both queues fill
    // and full has to hold the sender off.
    initial
    begin : receiver
        int unsigned hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = idle_draw();
            if (results_taken == PRESSURE_AT)
            begin
                hold = PRESSURE_HOLD;
            end
            else if ($urandom_range(0, 399) == 0)
            begin
                hold = $urandom_range(40, 120);
            end
            if (hold != 0)
            begin
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            last_busy = result.busy_res;
            results_taken++;
        end
    end

    initial
    begin : stimulus
        logic [15:0] dur [4];
        logic [15:0] gap;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: a tick while idle does nothing, then a frame with green
        // all zeros ahead of red and blue all ones, a load offered while the frame
        // is running, which must be refused, and enough ticks to see the first
        // bits go out with the default timing.
        send_item(colour_item(CMD_TICK, 8'hFF, 8'hFF, 8'hFF));
        send_item(colour_item(CMD_LOAD, 8'hFF, 8'h00, 8'hFF));
        send_item(colour_item(CMD_LOAD, 8'h00, 8'hFF, 8'h00));
        repeat (OPENING_TICKS)
        begin
            send_item(colour_item(CMD_TICK, 8'h00, 8'h00, 8'h00));
        end
        drain_queues();

        // Shortest legal timing, taken over by the running frame at its next phase.
        set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        finish_frame();

        // Zero settings must act as a single tick. Writes to indexes past the
        // register list must change nothing.
        set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        for (int k = int'(REG_FIRST_UNUSED); k < (1 << CFG_INDEX_W); k++)
        begin
            write_reg(CFG_INDEX_W'(k), '1);
        end
        cfg_valid <= 1'b0;
        send_item(colour_item(CMD_LOAD, 8'h5A, 8'hA5, 8'hC3));
        finish_frame();

        // Data bits above an eight-bit register's width are dropped.
        set_timing(16'hAB02, 16'h5403, 16'hFF01, 16'h0102, 16'd6);
        send_item(colour_item(CMD_LOAD, 8'h3C, 8'h81, 8'h7E));
        finish_frame();

        // Random phases: each picks a short timing setting so that frames complete,
        // sometimes with junk in the upper data bits, then runs a stream of ticks
        // with an occasional load. Loads that land during a frame are refused;
        // loads after a frame start the next one.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            foreach (dur[i])
            begin
                dur[i][7:0] = 8'($urandom_range(0, 2));
                dur[i][15:8] = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
            end
            gap = 16'($urandom_range(0, 6));
            set_timing(dur[0], dur[1], dur[2], dur[3], gap);
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_INDEX_W'($urandom_range(int'(REG_FIRST_UNUSED),
                                                      (1 << CFG_INDEX_W) - 1)),
                          16'($urandom));
                cfg_valid <= 1'b0;
            end
            repeat (ITEMS_PER_PHASE)
            begin
                send_item(random_item(LOAD_ODDS));
            end
            finish_frame();
        end
        no_idle = 1'b0;

        // Everything has been returned; give a stray result time to show up.
        drain_queues();
        repeat (SETTLE_CYCLES) @(posedge clk);
        finishing <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rlps_pkg.sv
hw/rtl/rlps_fifo.sv
hw/rtl/rlps_front.sv
hw/rtl/rlps_back.sv
hw/rtl/rgb_led_pulse_width_serializer.sv
verif/led_line_checker.sv
verif/testbench.sv
